// File: sv/sfd_pkg.sv
// Shared constants and types for the serial frame deframer.
// No dependencies; used by sfd_fsm and serial_frame_deframer.
package sfd_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'h80;
  localparam logic [7:0] HDR_SECOND = 8'h81;
  localparam logic [7:0] TRAILER    = 8'h82;
  localparam logic [3:0] VER_HIGH   = 4'h1;

  localparam logic [2:0] PH_HUNT   = 3'd0;
  localparam logic [2:0] PH_HDR2   = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_LEN_HI = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;

  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_GOOD      = 2'd1;
  localparam logic [1:0] KIND_BADVER    = 2'd2;
  localparam logic [1:0] KIND_MALFORMED = 2'd3;

  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    logic [7:0] payload;
  } result_t;

endpackage

// File: sv/sfd_fsm.sv
// Frame phase tracker: header hunt, length capture, body count and outcome.
// Depends on sfd_pkg. Produces the result of the current byte combinationally.
module sfd_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_in,
  input  logic [3:0]          version_low,
  output sfd_pkg::result_t    result
);

  logic [2:0]  phase, phase_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] body_count, body_count_next;
  logic [7:0]  version_seen, version_seen_next;
  logic [7:0]  length_low_byte, length_low_byte_next;
  logic        last;
  logic        first_body;

  assign last       = ({1'b0, body_count} + 17'd1) >= {1'b0, frame_length};
  assign first_body = (body_count == 16'd0);

  always_comb begin
    phase_next           = phase;
    frame_length_next    = frame_length;
    body_count_next      = body_count;
    version_seen_next    = version_seen;
    length_low_byte_next = length_low_byte;
    result               = '0;
    unique case (phase)
      sfd_pkg::PH_HDR2: begin
        phase_next = (byte_in == sfd_pkg::HDR_SECOND) ? sfd_pkg::PH_LEN_LO : sfd_pkg::PH_HUNT;
      end
      sfd_pkg::PH_LEN_LO: begin
        length_low_byte_next = byte_in;
        phase_next           = sfd_pkg::PH_LEN_HI;
      end
      sfd_pkg::PH_LEN_HI: begin
        frame_length_next = {byte_in, length_low_byte};
        body_count_next   = 16'd0;
        if ({byte_in, length_low_byte} == 16'd0) begin
          phase_next     = sfd_pkg::PH_HUNT;
          result.emit    = 1'b1;
          result.kind    = sfd_pkg::KIND_MALFORMED;
        end else begin
          phase_next = sfd_pkg::PH_BODY;
        end
      end
      sfd_pkg::PH_BODY: begin
        body_count_next = body_count + 16'd1;
        if (first_body) begin
          version_seen_next = byte_in;
        end
        if (last) begin
          phase_next  = sfd_pkg::PH_HUNT;
          result.emit = 1'b1;
          if (frame_length < 16'd2 || byte_in != sfd_pkg::TRAILER) begin
            result.kind = sfd_pkg::KIND_MALFORMED;
          end else if (version_seen != {sfd_pkg::VER_HIGH, version_low}) begin
            result.kind = sfd_pkg::KIND_BADVER;
          end else begin
            result.kind = sfd_pkg::KIND_GOOD;
          end
        end else if (!first_body) begin
          result.emit    = 1'b1;
          result.kind    = sfd_pkg::KIND_PAYLOAD;
          result.payload = byte_in;
        end
      end
      default: begin
        phase_next = (byte_in == sfd_pkg::HDR_FIRST) ? sfd_pkg::PH_HDR2 : sfd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= sfd_pkg::PH_HUNT;
      frame_length    <= 16'd0;
      body_count      <= 16'd0;
      version_seen    <= 8'd0;
      length_low_byte <= 8'd0;
    end else if (step) begin
      phase           <= phase_next;
      frame_length    <= frame_length_next;
      body_count      <= body_count_next;
      version_seen    <= version_seen_next;
      length_low_byte <= length_low_byte_next;
    end
  end

endmodule

// File: sv/serial_frame_deframer.sv
// Serial frame deframer top level: input register, phase tracker, result register.
// Depends on sfd_pkg and sfd_fsm.
//
// Takes one received byte per cycle while in_stall is low and reports payload
// bytes and frame outcomes (good, wrong version, malformed) on the result channel.
// Each byte is held in the input register, then resolved into the result register;
// throughput is one byte per cycle while results are taken, and the
// input stalls only while the result register is full and stalled. user_version
// may be written at any time the block is idle; cfg_ready is always high.
module serial_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] payload,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] user_version
);

  logic             in_full;
  logic [7:0]       in_byte;
  logic [3:0]       version_low;
  logic             advance;
  sfd_pkg::result_t result;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = in_full && !advance;

  sfd_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .step        (in_full && advance),
    .byte_in     (in_byte),
    .version_low (version_low),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      version_low <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      version_low <= user_version;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full && result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind    <= result.kind;
      payload <= result.payload;
    end
  end

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != sfd_pkg::KIND_PAYLOAD |-> payload == 8'd0)
    else $error("payload nonzero on outcome report");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without result backpressure");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule
